@@ hdl/indexed_array_insert_delete_top_defines.svh @@
// Assertion macros shared by the indexed array RTL.
// No dependencies; included inside module bodies.
`ifndef INDEXED_ARRAY_INSERT_DELETE_TOP_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IAID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IAID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/iaid_pkg.sv @@
// Package for the indexed array block: field widths, op and status codes,
// sequencer state type. No dependencies.
package iaid_pkg;

    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESP
    } state_t;

endpackage

@@ hdl/indexed_array_insert_delete_top.sv @@
// Indexed array with insert, delete, update and display over one entry memory.
// Depends on iaid_pkg and indexed_array_insert_delete_top_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries op, position, new_value.
//   Output channel (out_valid/out_stall) carries status, entry_value,
//   entry_index, element_count, last. An item moves on a rising edge with
//   valid high and stall low.
//   One item is worked at a time; in_stall is high until its last result is
//   in the output register.
//   Display of n entries: each entry is read through the single registered
//   read port of the entry memory, one per cycle while the output register is not held.
//   Insert/delete moving k > 0 entries: one entry moved per cycle through the
//   read-then-write-back path.
//   Update, bad index, full, insert or delete at the end move no entries.
//   The worst case is an insert at index 0 into DEPTH - 1 entries.
//   Reset clears the count and control; entry memory is not cleared.
//   While out_valid and out_stall are high the output register holds and the sequencer waits in S_DISP or S_RESP.
module indexed_array_insert_delete_top #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [iaid_pkg::OP_W-1:0]           op,
    input  logic [iaid_pkg::POS_W-1:0]          position,
    input  logic signed [iaid_pkg::VAL_W-1:0]   new_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [iaid_pkg::ST_W-1:0]           status,
    output logic signed [iaid_pkg::VAL_W-1:0]   entry_value,
    output logic [iaid_pkg::IDX_W-1:0]          entry_index,
    output logic [iaid_pkg::CNT_W-1:0]          element_count,
    output logic                                last
);

    import iaid_pkg::*;
    `include "indexed_array_insert_delete_top_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  out_st_reg, out_st_next;
    logic [VAL_W-1:0] out_val_reg, out_val_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic             out_last_reg, out_last_next;
    logic             out_load;
    logic             out_free;

    logic             accept;
    logic             shift_last;
    logic             disp_last;
    logic [AW-1:0]    cnt_m1;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_m1   = AW'(count_reg - CNT_W'(1));

    assign shift_last = (op_reg == OP_INSERT) ? (idx_reg == pos_reg[AW-1:0])
                                              : (idx_reg == cnt_m1);
    assign disp_last  = (idx_reg == cnt_m1);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pending shift write takes priority; it never coincides with S_PUT.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = rd_data_reg;
        if (wr_pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = val_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_DISPLAY:
                            state_next = (count_reg == '0) ? S_RESP : S_DISP;
                        OP_INSERT:
                            if (position > count_reg || count_reg == FULL_CNT)
                                state_next = S_RESP;
                            else if (position == count_reg)
                                state_next = S_PUT;
                            else
                                state_next = S_SHIFT;
                        OP_DELETE:
                            if (position >= count_reg)
                                state_next = S_RESP;
                            else if (position + POS_W'(1) == count_reg)
                                state_next = S_RESP;
                            else
                                state_next = S_SHIFT;
                        default:
                            state_next = (position >= count_reg) ? S_RESP : S_PUT;
                    endcase
                end
            end
            S_DISP:
                if (out_free && disp_last)
                    state_next = S_IDLE;
            S_SHIFT:
                if (shift_last)
                    state_next = S_DRAIN;
            S_DRAIN:
                state_next = (op_reg == OP_INSERT) ? S_PUT : S_RESP;
            S_PUT:
                state_next = S_RESP;
            S_RESP:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        st_next       = st_reg;
        idx_next      = idx_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        out_load      = 1'b0;
        out_st_next   = out_st_reg;
        out_val_next  = out_val_reg;
        out_idx_next  = out_idx_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op;
                    pos_next = position;
                    val_next = new_value;
                    st_next  = ST_OK;
                    case (op)
                        OP_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next = '0;
                                rd_en    = 1'b1;
                                rd_addr  = '0;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (position > count_reg)
                                st_next = ST_BADIDX;
                            else if (count_reg == FULL_CNT)
                                st_next = ST_FULL;
                            idx_next = cnt_m1;
                        end
                        OP_DELETE:
                        begin
                            if (position >= count_reg)
                                st_next = ST_BADIDX;
                            else if (position + POS_W'(1) == count_reg)
                                count_next = count_reg - CNT_W'(1);
                            idx_next = AW'(position + POS_W'(1));
                        end
                        default:
                        begin
                            if (position >= count_reg)
                                st_next = ST_BADIDX;
                        end
                    endcase
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_st_next   = ST_OK;
                    out_val_next  = rd_data_reg;
                    out_idx_next  = IDX_W'(idx_reg);
                    out_cnt_next  = count_reg;
                    out_last_next = disp_last;
                    if (!disp_last)
                    begin
                        idx_next = idx_reg + AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                    end
                end
            end
            S_SHIFT:
            begin
                rd_en        = 1'b1;
                rd_addr      = idx_reg;
                wr_pend_next = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    wr_addr_next = idx_reg + AW'(1);
                    idx_next     = idx_reg - AW'(1);
                end
                else
                begin
                    wr_addr_next = idx_reg - AW'(1);
                    idx_next     = idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (op_reg == OP_DELETE)
                    count_next = count_reg - CNT_W'(1);
            end
            S_PUT:
            begin
                if (op_reg == OP_INSERT)
                    count_next = count_reg + CNT_W'(1);
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_st_next   = st_reg;
                    out_val_next  = '0;
                    out_idx_next  = '0;
                    out_cnt_next  = count_reg;
                    out_last_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        st_reg       <= st_next;
        idx_reg      <= idx_next;
        wr_addr_reg  <= wr_addr_next;
        out_st_reg   <= out_st_next;
        out_val_reg  <= out_val_next;
        out_idx_reg  <= out_idx_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign entry_value   = out_val_reg;
    assign entry_index   = out_idx_reg;
    assign element_count = out_cnt_reg;
    assign last          = out_last_reg;

    `IAID_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT, "count above depth")
    `IAID_ASSERT_SAME(a_no_write_disp, clk, rst_n, state_reg == S_DISP, !wr_en, "write during display")
    `IAID_ASSERT_NEXT(a_shift_wb, clk, rst_n, state_reg == S_SHIFT, wr_pend_reg, "shift read without write-back")
    `IAID_ASSERT_NEXT(a_disp_start, clk, rst_n, accept && op == OP_DISPLAY && count_reg != '0, state_reg == S_DISP, "display not started")
    `IAID_ASSERT_NEXT(a_disp_end, clk, rst_n, state_reg == S_DISP && out_load && disp_last, state_reg == S_IDLE && out_valid_reg && out_last_reg, "display did not end on last")

endmodule
